// File: hw/rtl/lidar_scan_point_resampler_core_defines.svh
// ----------------------------------------------------------------------------
// lidar scan point resampler assertion macros
// shared concurrent check forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_POINT_RESAMPLER_CORE_DEFINES_SVH
`define LIDAR_SCAN_POINT_RESAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define LSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold
`define LSR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// types and constants of the lidar scan point resampler
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int unsigned ANGLE_W = 17;
  localparam logic signed [ANGLE_W-1:0] FULL_TURN_Q6   = 17'sd23040;
  localparam logic signed [ANGLE_W-1:0] PREV_ANGLE_RST = -17'sd64;
  localparam logic [15:0] OFFSET_RST = 16'd968;
  localparam logic [16:0] GAIN_RST   = 17'd59578;

  typedef enum logic [0:0] {
    CFG_OFFSET = 1'b0,
    CFG_GAIN   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SYNC     = 3'd0,
    PH_ANGLE_LO = 3'd1,
    PH_ANGLE_HI = 3'd2,
    PH_DIST_LO  = 3'd3,
    PH_DIST_HI  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [8:0]  bin_slot;
    logic [15:0] range_q2;
    logic [5:0]  intensity;
    logic        scan_done;
    logic [15:0] points_seen;
  } out_beat_t;

  // framed point, framer to binner
  typedef struct packed {
    logic        vld;
    logic [5:0]  quality;
    logic [14:0] angle;
    logic [15:0] raw;
    logic [15:0] tally;
  } point_t;

  // binned point, binner to selector
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic        prev_near;
    logic        neg;
    logic        done;
    logic [5:0]  quality;
    logic [32:0] prod;
    logic [8:0]  slot;
    logic [15:0] tally;
  } stage_t;

endpackage

// File: hw/rtl/lsr_stream_if.sv
// ----------------------------------------------------------------------------
// lsr_stream_if
// valid/ready channel carrying one beat of type T
// ----------------------------------------------------------------------------
interface lsr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/lsr_framer.sv
// ----------------------------------------------------------------------------
// lsr_framer
// aligns the serial byte stream into 5-byte points and keeps the point tally
// ----------------------------------------------------------------------------
module lsr_framer import lsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       room_i,
  input  logic       scan_clr_i,
  output logic       rx_ready_o,
  output point_t     pt_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] tally_q, tally_d;
  logic        pt_vld_q, pt_vld_d;
  logic [7:0]  b0_q, b1_q, b2_q, b3_q;
  logic [5:0]  quality_q;
  logic [14:0] angle_q;
  logic [15:0] raw_q;
  logic [15:0] pt_tally_q;
  logic        acc;

  // last byte of a point only when the result has room
  assign rx_ready_o = (phase_q != PH_DIST_HI) || room_i;
  assign acc        = rx_valid_i && rx_ready_o;

  always_comb begin
    phase_d  = phase_q;
    tally_d  = tally_q;
    pt_vld_d = 1'b0;
    if (scan_clr_i) begin
      tally_d = '0;
    end
    if (acc) begin
      case (phase_q)
        PH_SYNC: begin
          if (rx_byte_i[1:0] inside {2'b01, 2'b10}) begin
            phase_d = PH_ANGLE_LO;
          end else begin
            tally_d = '0;
          end
        end
        PH_ANGLE_LO: begin
          if (rx_byte_i[0]) begin
            phase_d = PH_ANGLE_HI;
            if (tally_q != '1) begin
              tally_d = tally_q + 16'd1;
            end
          end else begin
            phase_d = PH_SYNC;
            tally_d = '0;
          end
        end
        PH_ANGLE_HI: phase_d = PH_DIST_LO;
        PH_DIST_LO:  phase_d = PH_DIST_HI;
        PH_DIST_HI: begin
          phase_d  = PH_SYNC;
          pt_vld_d = 1'b1;
        end
        default: phase_d = PH_SYNC;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC;
      tally_q  <= '0;
      pt_vld_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      tally_q  <= tally_d;
      pt_vld_q <= pt_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      case (phase_q)
        PH_SYNC:     b0_q <= rx_byte_i;
        PH_ANGLE_LO: b1_q <= rx_byte_i;
        PH_ANGLE_HI: b2_q <= rx_byte_i;
        PH_DIST_LO:  b3_q <= rx_byte_i;
        PH_DIST_HI: begin
          quality_q  <= b0_q[7:2];
          angle_q    <= {b2_q, b1_q[7:1]};
          raw_q      <= {rx_byte_i, b3_q};
          pt_tally_q <= tally_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pt_o.vld     = pt_vld_q;
    pt_o.quality = quality_q;
    pt_o.angle   = angle_q;
    pt_o.raw     = raw_q;
    pt_o.tally   = pt_tally_q;
  end

endmodule

// File: hw/rtl/lsr_binner.sv
// ----------------------------------------------------------------------------
// lsr_binner
// range correction product, bin window test and bin/angle state
// ----------------------------------------------------------------------------
module lsr_binner import lsr_pkg::*; #(
  parameter int unsigned BINS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  point_t      pt_i,
  input  logic [15:0] offset_i,
  input  logic [16:0] gain_i,
  output logic        scan_clr_o,
  output stage_t      s_o
);

  localparam int unsigned CW   = $clog2(BINS);
  localparam int unsigned PW   = ANGLE_W + CW + 2;
  localparam int unsigned HALF = BINS / 2;
  localparam logic signed [PW-1:0] BINS_S = PW'(BINS);

  logic        [CW-1:0]      bin_q, bin_d;
  logic signed [ANGLE_W-1:0] prev_angle_q, prev_angle_d;
  logic signed [ANGLE_W-1:0] cur_angle;
  logic signed [PW-1:0]      pos_bin, pos_prev, pos_cur, gap_prev, gap_cur;
  logic        [CW:0]        slot_w;
  logic        [15:0]        diff;
  logic                      hit, last, prev_near, neg;
  logic                      s_vld_q;
  stage_t                    s_q;

  assign cur_angle = signed'(ANGLE_W'(pt_i.angle));
  assign pos_bin   = signed'(PW'(bin_q)) * signed'(PW'(FULL_TURN_Q6));
  assign pos_prev  = PW'(prev_angle_q) * BINS_S;
  assign pos_cur   = signed'(PW'(pt_i.angle)) * BINS_S;
  assign gap_prev  = pos_bin - pos_prev;
  assign gap_cur   = pos_cur - pos_bin;
  assign hit       = (pos_bin >= pos_prev) && (pos_bin < pos_cur) && (cur_angle > prev_angle_q);
  assign prev_near = gap_prev < gap_cur;
  assign last      = bin_q == CW'(BINS - 1);
  assign neg       = pt_i.raw < offset_i;
  assign diff      = pt_i.raw - offset_i;

  // reversed, half-rotated slot
  always_comb begin
    if (bin_q < CW'(HALF)) begin
      slot_w = (CW + 1)'(HALF - 1) - (CW + 1)'(bin_q);
    end else begin
      slot_w = (CW + 1)'(BINS - 1 + HALF) - (CW + 1)'(bin_q);
    end
  end

  assign scan_clr_o = pt_i.vld && hit && last;

  always_comb begin
    bin_d        = bin_q;
    prev_angle_d = prev_angle_q;
    if (pt_i.vld) begin
      prev_angle_d = cur_angle;
      if (hit) begin
        if (last) begin
          bin_d        = '0;
          prev_angle_d = cur_angle - FULL_TURN_Q6;
        end else begin
          bin_d = bin_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q        <= '0;
      prev_angle_q <= PREV_ANGLE_RST;
      s_vld_q      <= 1'b0;
    end else begin
      bin_q        <= bin_d;
      prev_angle_q <= prev_angle_d;
      s_vld_q      <= pt_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_i.vld) begin
      s_q.vld       <= 1'b1;
      s_q.hit       <= hit;
      s_q.prev_near <= prev_near;
      s_q.neg       <= neg;
      s_q.done      <= last;
      s_q.quality   <= pt_i.quality;
      s_q.prod      <= 33'(diff) * 33'(gain_i);
      s_q.slot      <= 9'(slot_w);
      s_q.tally     <= pt_i.tally;
    end
  end

  always_comb begin
    s_o     = s_q;
    s_o.vld = s_vld_q;
  end

endmodule

// File: hw/rtl/lsr_select.sv
// ----------------------------------------------------------------------------
// lsr_select
// saturates the range, picks the nearer sample and keeps the previous one
// ----------------------------------------------------------------------------
module lsr_select import lsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stage_t    s_i,
  output logic      res_vld_o,
  output out_beat_t res_o
);

  logic [15:0] prev_range_q, prev_range_d;
  logic [5:0]  prev_qual_q, prev_qual_d;
  logic        prev_neg_q, prev_neg_d;
  logic [15:0] range, r;
  logic [5:0]  q;

  always_comb begin
    if (s_i.neg) begin
      range = '0;
    end else if (s_i.prod[32]) begin
      range = '1;
    end else begin
      range = s_i.prod[31:16];
    end
  end

  always_comb begin
    prev_range_d = prev_range_q;
    prev_qual_d  = prev_qual_q;
    prev_neg_d   = prev_neg_q;
    r            = range;
    q            = s_i.quality;
    if (s_i.hit && (s_i.neg || prev_neg_q)) begin
      r = '0;
      q = '0;
    end else if (s_i.hit && s_i.prev_near) begin
      r = prev_range_q;
      q = prev_qual_q;
    end
    if (s_i.vld) begin
      if (s_i.hit && (s_i.neg || prev_neg_q)) begin
        prev_range_d = '0;
        prev_qual_d  = '0;
        prev_neg_d   = 1'b0;
      end else begin
        prev_range_d = range;
        prev_qual_d  = s_i.quality;
        prev_neg_d   = s_i.neg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_range_q <= '0;
      prev_qual_q  <= '0;
      prev_neg_q   <= 1'b0;
    end else begin
      prev_range_q <= prev_range_d;
      prev_qual_q  <= prev_qual_d;
      prev_neg_q   <= prev_neg_d;
    end
  end

  assign res_vld_o         = s_i.vld && s_i.hit;
  assign res_o.bin_slot    = s_i.slot;
  assign res_o.range_q2    = r;
  assign res_o.intensity   = q;
  assign res_o.scan_done   = s_i.done;
  assign res_o.points_seen = s_i.done ? s_i.tally : 16'd0;

endmodule

// File: hw/rtl/lsr_out_queue.sv
// ----------------------------------------------------------------------------
// lsr_out_queue
// two-entry result queue, a ring of two entries with write and read pointers
// ----------------------------------------------------------------------------
module lsr_out_queue import lsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  out_beat_t  wr_data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output out_beat_t  data_o,
  output logic [1:0] cnt_o
);

  out_beat_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       rd;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign rd      = valid_o && ready_i;
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: hw/rtl/lidar_scan_point_resampler_core.sv
// ----------------------------------------------------------------------------
// lidar_scan_point_resampler_core
// frames scanner bytes into points and writes angular bins of a scan
// ----------------------------------------------------------------------------
//  channel   dir  beat        handshake
//  rx_i      in   in_beat_t   valid/ready
//  bin_o     out  out_beat_t  valid/ready
//  cfg       in   index+data  cfg_we_i, no back-pressure
//
//  one byte is taken every cycle unless a last byte waits; a bin beat
//  passes framer register, binner stage, then selector into the queue.
//  the last byte of a point waits while the two-entry queue plus the point
//  in flight leave no room; other bytes are always taken.
//  reset clears framing, bin counter, previous sample and queue at once.
// ----------------------------------------------------------------------------
`include "lidar_scan_point_resampler_core_defines.svh"

module lidar_scan_point_resampler_core import lsr_pkg::*; #(
  parameter int unsigned BINS = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsr_stream_if.sink    rx_i,
  lsr_stream_if.source  bin_o,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [16:0]   cfg_wdata_i
);

  logic [15:0] offset_q, offset_d;
  logic [16:0] gain_q, gain_d;
  point_t      pt;
  stage_t      sa;
  logic        scan_clr, room, res_vld;
  out_beat_t   res;
  logic [1:0]  q_cnt;

  always_comb begin
    offset_d = offset_q;
    gain_d   = gain_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET: offset_d = cfg_wdata_i[15:0];
        CFG_GAIN:   gain_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
      gain_q   <= GAIN_RST;
    end else begin
      offset_q <= offset_d;
      gain_q   <= gain_d;
    end
  end

  // room for one more result counting the point in flight
  assign room = ({1'b0, q_cnt} + {2'b00, (pt.vld || sa.vld)}) < 3'd2;

  lsr_framer u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_byte_i  (rx_i.data.rx_byte),
    .room_i     (room),
    .scan_clr_i (scan_clr),
    .rx_ready_o (rx_i.ready),
    .pt_o       (pt)
  );

  lsr_binner #(
    .BINS (BINS)
  ) u_binner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_i       (pt),
    .offset_i   (offset_q),
    .gain_i     (gain_q),
    .scan_clr_o (scan_clr),
    .s_o        (sa)
  );

  lsr_select u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_i       (sa),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  lsr_out_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_vld),
    .wr_data_i (res),
    .valid_o   (bin_o.valid),
    .ready_i   (bin_o.ready),
    .data_o    (bin_o.data),
    .cnt_o     (q_cnt)
  );

  `LSR_ASSERT_NEVER(a_one_point_in_flight, pt.vld && sa.vld, "two points in flight")
  `LSR_ASSERT_NXT(a_point_reaches_stage, pt.vld, sa.vld, "point lost before binner stage")
  `LSR_ASSERT_IMP(a_queue_has_room, res_vld, q_cnt != 2'd2, "result written into full queue")
  `LSR_ASSERT_IMP(a_tally_only_at_end, res_vld && !res.scan_done, res.points_seen == 16'd0, "tally outside scan end")

endmodule
